>>> design/spiral_order_matrix_reader_macros.svh
// ----------------------------------------------------------------------------
// Spiral order matrix reader assertion macros
// Shared helpers for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef SPIRAL_ORDER_MATRIX_READER_MACROS_SVH
`define SPIRAL_ORDER_MATRIX_READER_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SOM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SOM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/som_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spiral order matrix reader package
// Widths, register indexes, state types and helpers shared by the block.
// ----------------------------------------------------------------------------
package som_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W = 4;
  localparam int TOT_W = 2 * CFG_W;
  localparam int POS_W = 3;

  localparam int DEF_MAX_ROWS = 8;
  localparam int DEF_MAX_COLS = 8;

  localparam logic [CFG_W-1:0] RESET_DIM = 4'd8;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } som_state_e;

  typedef enum logic [1:0] {
    PH_TOP,
    PH_RIGHT,
    PH_BOTTOM,
    PH_LEFT
  } som_phase_e;

  typedef struct packed {
    logic start;
    logic advance;
  } som_seq_ctrl_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } som_pos_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end
    return res;
  endfunction

endpackage

>>> design/spiral_order_matrix_reader.sv
`timescale 1ns / 1ps
// The input is not stalled while loading, so every valid element is accepted.
// After the final element is accepted the block enters emission and then loads the store
// read register for the first result; one result per cycle leaves that register unless out_stall_i holds it.
// The input stalls during emission.
// Reset sets both dimensions to 8 and clears the load count; the store is not cleared.
// ----------------------------------------------------------------------------
// Spiral order matrix reader
// Loads a matrix in row-major order and emits it in clockwise spiral order.
// ----------------------------------------------------------------------------
module spiral_order_matrix_reader import som_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] element_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic [POS_W-1:0]         out_row_o,
  output logic [POS_W-1:0]         out_col_o,
  output logic                     last_of_run_o
);

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [CFG_W-1:0] MaxR = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] MaxC = CFG_W'(MAX_COLS);

  som_state_e       state_q, state_d;
  logic [CFG_W-1:0] rows_q;
  logic [CFG_W-1:0] cols_q;
  logic [CFG_W-1:0] rows_eff;
  logic [CFG_W-1:0] cols_eff;
  logic [TOT_W-1:0] total;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  count_base;
  logic [CntW-1:0]  count_inc;
  logic             in_accept;
  logic             out_free;
  logic             out_valid_q, out_valid_d;
  logic             mem_we;
  logic             mem_re;
  som_seq_ctrl_t    seq_ctrl;
  som_pos_t         seq_pos;
  som_pos_t         out_pos_q;
  logic [AddrW-1:0] seq_addr;
  logic [DATA_W-1:0] rdata;

  assign rows_eff = clamp_dim(rows_q, MaxR);
  assign cols_eff = clamp_dim(cols_q, MaxC);
  assign total = TOT_W'(rows_eff) * TOT_W'(cols_eff);

  assign in_stall_o = (state_q == ST_EMIT);
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign count_base = (TOT_W'(count_q) >= total) ? '0 : count_q;
  assign count_inc = count_base + CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RESET_DIM;
      cols_q <= RESET_DIM;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ROWS: rows_q <= cfg_data_i;
        REG_COLS: cols_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    mem_we = 1'b0;
    mem_re = 1'b0;
    seq_ctrl.start = 1'b0;
    seq_ctrl.advance = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_accept) begin
          mem_we = 1'b1;
          if (TOT_W'(count_inc) == total) begin
            count_d = '0;
            seq_ctrl.start = 1'b1;
            state_d = ST_EMIT;
          end else begin
            count_d = count_inc;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          mem_re = 1'b1;
          seq_ctrl.advance = 1'b1;
          out_valid_d = 1'b1;
          if (seq_pos.last) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      out_pos_q <= seq_pos;
    end
  end

  som_store #(
    .DEPTH (Depth),
    .ADDR_W(AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(count_base[AddrW-1:0]),
    .wdata_i(element_value_i),
    .re_i   (mem_re),
    .raddr_i(seq_addr),
    .rdata_o(rdata)
  );

  som_seq #(
    .ADDR_W(AddrW),
    .CNT_W (CntW)
  ) u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(seq_ctrl),
    .rows_i(rows_eff),
    .cols_i(cols_eff),
    .addr_o(seq_addr),
    .pos_o (seq_pos)
  );

  assign out_valid_o = out_valid_q;
  assign out_value_o = rdata;
  assign out_row_o = out_pos_q.row;
  assign out_col_o = out_pos_q.col;
  assign last_of_run_o = out_pos_q.last;

endmodule

>>> design/som_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spiral order matrix reader element store
// Single-port write, registered-read memory holding the loaded matrix.
// ----------------------------------------------------------------------------
module som_store import som_pkg::*; #(
  parameter int DEPTH  = DEF_MAX_ROWS * DEF_MAX_COLS,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/som_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spiral order matrix reader sequencer
// Walks the rings of the matrix and steps the store address with one adder.
// ----------------------------------------------------------------------------
module som_seq import som_pkg::*; #(
  parameter int ADDR_W = 6,
  parameter int CNT_W  = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  som_seq_ctrl_t     ctrl_i,
  input  logic [CFG_W-1:0]  rows_i,
  input  logic [CFG_W-1:0]  cols_i,
  output logic [ADDR_W-1:0] addr_o,
  output som_pos_t          pos_o
);

  som_phase_e        phase_q, phase_d;
  logic [CFG_W-1:0]  s_q, s_d;
  logic [CFG_W-1:0]  r_q, r_d;
  logic [CFG_W-1:0]  c_q, c_d;
  logic [ADDR_W-1:0] addr_q;
  logic [CNT_W-1:0]  delta;
  logic [CNT_W-1:0]  cols_ext;
  logic [CNT_W-1:0]  addr_sum;
  logic [CFG_W-1:0]  ex;
  logic [CFG_W-1:0]  ey;
  logic [CFG_W-1:0]  s1;
  logic              ring_ok;
  logic              last;

  assign ex = cols_i - CFG_W'(1) - s_q;
  assign ey = rows_i - CFG_W'(1) - s_q;
  assign s1 = s_q + CFG_W'(1);
  assign ring_ok = ({1'b0, cols_i} > {s1, 1'b0}) && ({1'b0, rows_i} > {s1, 1'b0});
  assign cols_ext = CNT_W'(cols_i);

  always_comb begin
    phase_d = phase_q;
    s_d = s_q;
    r_d = r_q;
    c_d = c_q;
    delta = CNT_W'(1);
    last = 1'b0;
    unique case (phase_q)
      PH_TOP: begin
        if (c_q < ex) begin
          c_d = c_q + CFG_W'(1);
        end else if (s_q < ey) begin
          r_d = r_q + CFG_W'(1);
          phase_d = PH_RIGHT;
          delta = cols_ext;
        end else begin
          last = 1'b1;
        end
      end
      PH_RIGHT: begin
        if (r_q < ey) begin
          r_d = r_q + CFG_W'(1);
          delta = cols_ext;
        end else if (s_q < ex) begin
          c_d = c_q - CFG_W'(1);
          phase_d = PH_BOTTOM;
          delta = '1;
        end else begin
          last = 1'b1;
        end
      end
      PH_BOTTOM: begin
        if (c_q > s_q) begin
          c_d = c_q - CFG_W'(1);
          delta = '1;
        end else if (s1 < ey) begin
          r_d = r_q - CFG_W'(1);
          phase_d = PH_LEFT;
          delta = ~cols_ext + CNT_W'(1);
        end else begin
          last = 1'b1;
        end
      end
      PH_LEFT: begin
        if (r_q > s1) begin
          r_d = r_q - CFG_W'(1);
          delta = ~cols_ext + CNT_W'(1);
        end else if (ring_ok) begin
          s_d = s1;
          c_d = c_q + CFG_W'(1);
          phase_d = PH_TOP;
        end else begin
          last = 1'b1;
        end
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  assign addr_sum = CNT_W'(addr_q) + delta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOP;
      s_q <= '0;
      r_q <= '0;
      c_q <= '0;
      addr_q <= '0;
    end else if (ctrl_i.start) begin
      phase_q <= PH_TOP;
      s_q <= '0;
      r_q <= '0;
      c_q <= '0;
      addr_q <= '0;
    end else if (ctrl_i.advance) begin
      phase_q <= phase_d;
      s_q <= s_d;
      r_q <= r_d;
      c_q <= c_d;
      addr_q <= addr_sum[ADDR_W-1:0];
    end
  end

  assign addr_o = addr_q;
  assign pos_o.row = r_q[POS_W-1:0];
  assign pos_o.col = c_q[POS_W-1:0];
  assign pos_o.last = last;

endmodule

>>> design/som_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spiral order matrix reader checker
// Port-level checks on the load and emission sequencing of the block.
// ----------------------------------------------------------------------------
`include "spiral_order_matrix_reader_macros.svh"

module som_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic last_of_run_o
);

  `SOM_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "Output transaction dropped while stalled.")
  `SOM_ASSERT_IMP(a_busy_mid_run, out_valid_o && !last_of_run_o, in_stall_o, "Input open before the spiral finished.")
  `SOM_ASSERT_NXT(a_gap_after_last, out_valid_o && !out_stall_i && last_of_run_o, !out_valid_o, "Result follows the last transaction at once.")
  `SOM_ASSERT_IMP(a_emit_after_load, $rose(in_stall_o), $past(in_valid_i && !in_stall_o), "Emission began without a final input transaction.")

endmodule

bind spiral_order_matrix_reader som_checker u_som_checker (.*);

>>> tb/tb_spiral_order_matrix_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spiral order matrix reader testbench
// Loads matrices of many sizes in row-major order and checks that every
// element comes back in clockwise spiral order with its row, column and last
// flag. A local predictor follows each accepted input transaction. Random gaps
// in the input, random output stalls, partial loads with size changes, and
// out-of-range size values are part of the stimulus.
// ----------------------------------------------------------------------------
module tb_spiral_order_matrix_reader;
  import som_pkg::*;

  localparam int MAX_R = DEF_MAX_ROWS;
  localparam int MAX_C = DEF_MAX_COLS;
  localparam int STORE_DEPTH = 64;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 250;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 9;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    som_pos_t                 pos;
  } spiral_elem_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic                     cfg_index_i = REG_ROWS;
  logic [CFG_W-1:0]         cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] element_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] out_value_o;
  logic [POS_W-1:0]         out_row_o;
  logic [POS_W-1:0]         out_col_o;
  logic                     last_of_run_o;

  logic signed [DATA_W-1:0] element_feed_q[$];
  spiral_elem_t             spiral_order_q[$];

  logic [DATA_W-1:0] elem_store [STORE_DEPTH];
  int                load_cnt = 0;
  logic [CFG_W-1:0]  rows_reg = RESET_DIM;
  logic [CFG_W-1:0]  cols_reg = RESET_DIM;
  int                spiral_idx;
  int                spiral_len;

  logic quiet = 1'b0;
  int   mismatch_cnt = 0;
  int   cycle_cnt = 0;

  spiral_order_matrix_reader i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_value_o     (out_value_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .last_of_run_o   (last_of_run_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int dim_in_use(input logic [CFG_W-1:0] v, input int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic int matrix_size();
    return dim_in_use(rows_reg, MAX_R) * dim_in_use(cols_reg, MAX_C);
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return '0;
    if (sel == 1) return CFG_W'($urandom_range(15, 9));
    if (sel < 4) return CFG_W'(8);
    return CFG_W'($urandom_range(4, 1));
  endfunction

  task automatic add_spiral_elem(input int r, input int c, input int nc);
    spiral_elem_t e;
    e.value = elem_store[(r * nc + c) % STORE_DEPTH];
    e.pos.row = POS_W'(r);
    e.pos.col = POS_W'(c);
    e.pos.last = (spiral_idx == spiral_len - 1);
    spiral_order_q.push_back(e);
    spiral_idx++;
  endtask

  task automatic predict_element(input logic signed [DATA_W-1:0] v);
    int nr;
    int nc;
    int total;
    int ring;
    int ex;
    int ey;
    int i;
    nr = dim_in_use(rows_reg, MAX_R);
    nc = dim_in_use(cols_reg, MAX_C);
    total = nr * nc;
    if (load_cnt >= total) load_cnt = 0;
    elem_store[load_cnt % STORE_DEPTH] = v;
    load_cnt = (load_cnt + 1) & 8'h7f;
    if (load_cnt < total) return;
    spiral_len = total;
    spiral_idx = 0;
    ring = 0;
    while (nc > 2 * ring && nr > 2 * ring) begin
      ex = nc - 1 - ring;
      ey = nr - 1 - ring;
      for (i = ring; i <= ex; i++) add_spiral_elem(ring, i, nc);
      if (ring < ey) begin
        for (i = ring + 1; i <= ey; i++) add_spiral_elem(i, ex, nc);
      end
      if (ring < ex && ring < ey) begin
        for (i = ex - 1; i >= ring; i--) add_spiral_elem(ey, i, nc);
      end
      if (ring < ex && ring < ey - 1) begin
        for (i = ey - 1; i >= ring + 1; i--) add_spiral_elem(i, ring, nc);
      end
      ring++;
    end
    load_cnt = 0;
  endtask

  task automatic write_dim_reg(input logic idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ROWS) begin
      rows_reg = data;
    end else begin
      cols_reg = data;
    end
  endtask

  function automatic void queue_random(input int n);
    int k;
    for (k = 0; k < n; k++) element_feed_q.push_back($urandom);
  endfunction

  // Queues the elements that complete the run under the current size.
  function automatic int finish_run();
    int total;
    int n;
    total = matrix_size();
    n = (load_cnt >= total) ? total : total - load_cnt;
    queue_random(n);
    return n;
  endfunction

  task automatic wait_drained();
    while (element_feed_q.size() != 0 || in_valid_i || spiral_order_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (element_feed_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid_i <= 1'b1;
        element_value_i <= element_feed_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin : monitor
    spiral_elem_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_element(element_value_i);
      if (out_valid_o && !out_stall_i) begin
        if (spiral_order_q.size() == 0) begin
          $display("%0t: unexpected result: value %h row %0d col %0d last %0b", $time,
                   out_value_o, out_row_o, out_col_o, last_of_run_o);
          mismatch_cnt++;
        end else begin
          want = spiral_order_q.pop_front();
          if (out_value_o !== want.value) begin
            $display("%0t: out_value expected %h, actual %h", $time, want.value,
                     out_value_o);
            mismatch_cnt++;
          end
          if (out_row_o !== want.pos.row) begin
            $display("%0t: out_row expected %0d, actual %0d", $time, want.pos.row,
                     out_row_o);
            mismatch_cnt++;
          end
          if (out_col_o !== want.pos.col) begin
            $display("%0t: out_col expected %0d, actual %0d", $time, want.pos.col,
                     out_col_o);
            mismatch_cnt++;
          end
          if (last_of_run_o !== want.pos.last) begin
            $display("%0t: last_of_run expected %0b, actual %0b", $time, want.pos.last,
                     last_of_run_o);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, spiral_order_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int random_items;
    int phase_cnt;
    int total;
    int part;
    random_items = 0;
    phase_cnt = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A zero row count acts as one and an oversized column count as eight.
    write_dim_reg(REG_ROWS, 4'd0);
    write_dim_reg(REG_COLS, 4'd15);
    element_feed_q.push_back(32'sh8000_0000);
    element_feed_q.push_back(32'sh7fff_ffff);
    element_feed_q.push_back(32'sh0000_0000);
    element_feed_q.push_back(-32'sd1);
    queue_random(4);
    wait_drained();

    write_dim_reg(REG_ROWS, 4'd5);
    write_dim_reg(REG_COLS, 4'd0);
    void'(finish_run());
    wait_drained();

    // Shrinking below the loaded count restarts the run at position zero.
    write_dim_reg(REG_ROWS, 4'd3);
    write_dim_reg(REG_COLS, 4'd3);
    queue_random(5);
    wait_drained();
    write_dim_reg(REG_ROWS, 4'd2);
    write_dim_reg(REG_COLS, 4'd2);
    void'(finish_run());
    wait_drained();

    // A size change in the middle of a load keeps the loaded positions.
    write_dim_reg(REG_COLS, 4'd3);
    queue_random(2);
    wait_drained();
    write_dim_reg(REG_COLS, 4'd2);
    void'(finish_run());
    wait_drained();

    while (random_items < RANDOM_ITEMS) begin
      quiet = (phase_cnt >= 6 && phase_cnt < 14);
      write_dim_reg(REG_ROWS, pick_dim());
      write_dim_reg(REG_COLS, pick_dim());
      total = matrix_size();
      if (total > 1 && $urandom_range(99) < 15) begin
        part = $urandom_range(total - 1, 1);
        queue_random(part);
        random_items += part;
        wait_drained();
        write_dim_reg(REG_ROWS, pick_dim());
        write_dim_reg(REG_COLS, pick_dim());
      end
      random_items += finish_run();
      wait_drained();
      phase_cnt++;
    end
    quiet = 1'b0;

    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
